// File: design/rcsde_pkg.sv
// ----------------------------------------------------------------------------
// rcsde_pkg: shared types and constants
// Constants, register indexes and switch-path structs for the RC stick
// dead zone and switch edge block.
// ----------------------------------------------------------------------------
package rcsde_pkg;

    localparam int RAW_W   = 12;
    localparam int DZ_W    = 9;
    localparam int GAIN_W  = 24;
    localparam int STICK_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [RAW_W-1:0]   STICK_CENTER     = 12'd1500;
    localparam logic [RAW_W-1:0]   SWITCH_VALID_MAX = 12'd2100;
    localparam logic [STICK_W-2:0] Q14_ONE          = 15'd16384;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DZ_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STICK_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_THRESH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GEAR_THRESH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RBT_THRESH  = 3'd4;

    // Reset values
    localparam logic [DZ_W-1:0]   DZ_WIDTH_RST    = 9'd125;
    localparam logic [GAIN_W-1:0] STICK_GAIN_RST  = 24'd2863312;
    localparam logic [RAW_W-1:0]  MODE_THRESH_RST = 12'd1750;
    localparam logic [RAW_W-1:0]  GEAR_THRESH_RST = 12'd1750;
    localparam logic [RAW_W-1:0]  RBT_THRESH_RST  = 12'd1500;

    typedef struct packed {
        logic [RAW_W-1:0] mode;
        logic [RAW_W-1:0] gear;
        logic [RAW_W-1:0] reboot;
    } sw_raw_t;

    typedef struct packed {
        logic hover_active;
        logic hover_entered;
        logic command_active;
        logic command_entered;
        logic reboot_pulse;
    } sw_flags_t;

endpackage

// File: design/rc_stick_deadzone_and_switch_edges_top.sv
// ----------------------------------------------------------------------------
// rc_stick_deadzone_and_switch_edges_top: RC frame normalizer
// Four stick lanes with dead zone and Q1.14 scaling, plus switch edge flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one RC frame per request: four
//   stick pulse widths and the mode, gear and reboot switch widths.
//   Output channel (out_valid/out_ready) gives one result per frame: four
//   Q1.14 sticks and the switch/status flags.
//   Config channel (cfg_valid/cfg_ready) writes registers by index; always
//   ready. Write only while no frame is in flight.
// Path: a frame passes the input register, then the result register; one
//   gain multiply per stick lane sits between them.
// Throughput: one frame per cycle sustained while out_ready stays high,
//   set by the two-register pipe.
// Reset: pipe empties, config returns to defaults, switch history is cleared
//   and the first frame after reset seeds it (no edges on that frame).
// Stall: while out_ready is low the result holds; one more frame can wait in
//   the input register, after which in_ready drops until the result drains.
// ----------------------------------------------------------------------------
module rc_stick_deadzone_and_switch_edges_top (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [rcsde_pkg::RAW_W-1:0]            stick_raw_0,
    input  logic [rcsde_pkg::RAW_W-1:0]            stick_raw_1,
    input  logic [rcsde_pkg::RAW_W-1:0]            stick_raw_2,
    input  logic [rcsde_pkg::RAW_W-1:0]            stick_raw_3,
    input  logic [rcsde_pkg::RAW_W-1:0]            mode_raw,
    input  logic [rcsde_pkg::RAW_W-1:0]            gear_raw,
    input  logic [rcsde_pkg::RAW_W-1:0]            reboot_raw,

    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [rcsde_pkg::STICK_W-1:0]   stick_out_0,
    output logic signed [rcsde_pkg::STICK_W-1:0]   stick_out_1,
    output logic signed [rcsde_pkg::STICK_W-1:0]   stick_out_2,
    output logic signed [rcsde_pkg::STICK_W-1:0]   stick_out_3,
    output logic                                   hover_active,
    output logic                                   hover_entered,
    output logic                                   command_active,
    output logic                                   command_entered,
    output logic                                   reboot_pulse,
    output logic                                   frame_valid,
    output logic                                   sticks_centered,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [rcsde_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rcsde_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import rcsde_pkg::*;

    localparam int NUM_STICKS = 4;

    // ---------------- configuration registers ----------------
    logic [DZ_W-1:0]   dz_width_reg;
    logic [GAIN_W-1:0] gain_reg;
    sw_raw_t           thresh_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_width_reg      <= DZ_WIDTH_RST;
            gain_reg          <= STICK_GAIN_RST;
            thresh_reg.mode   <= MODE_THRESH_RST;
            thresh_reg.gear   <= GEAR_THRESH_RST;
            thresh_reg.reboot <= RBT_THRESH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DZ_WIDTH:    dz_width_reg      <= cfg_data[DZ_W-1:0];
                REG_STICK_GAIN:  gain_reg          <= cfg_data[GAIN_W-1:0];
                REG_MODE_THRESH: thresh_reg.mode   <= cfg_data[RAW_W-1:0];
                REG_GEAR_THRESH: thresh_reg.gear   <= cfg_data[RAW_W-1:0];
                REG_RBT_THRESH:  thresh_reg.reboot <= cfg_data[RAW_W-1:0];
                default:         ; // unmapped index, write dropped
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic advance;      // input register moves into result register
    logic in_fire;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- input register (payload, no reset) ----------------
    logic [RAW_W-1:0] stick_raw_reg [NUM_STICKS];
    sw_raw_t          sw_raw_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stick_raw_reg[0]  <= stick_raw_0;
            stick_raw_reg[1]  <= stick_raw_1;
            stick_raw_reg[2]  <= stick_raw_2;
            stick_raw_reg[3]  <= stick_raw_3;
            sw_raw_reg.mode   <= mode_raw;
            sw_raw_reg.gear   <= gear_raw;
            sw_raw_reg.reboot <= reboot_raw;
        end
    end

    // ---------------- compute ----------------
    logic signed [STICK_W-1:0] stick_next [NUM_STICKS];
    sw_flags_t                 flags_next;
    logic                      valid_next;
    logic                      centered_next;

    for (genvar g = 0; g < NUM_STICKS; g++)
    begin : g_lane
        rcsde_stick_lane u_lane (
            .raw       (stick_raw_reg[g]),
            .dz_width  (dz_width_reg),
            .gain      (gain_reg),
            .stick     (stick_next[g])
        );
    end

    // switch history and command flags advance with the frame
    rcsde_switch_logic u_switch (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .sw      (sw_raw_reg),
        .thresh  (thresh_reg),
        .flags   (flags_next)
    );

    always_comb
    begin
        valid_next = (sw_raw_reg.mode   <= SWITCH_VALID_MAX) &&
                     (sw_raw_reg.gear   <= SWITCH_VALID_MAX) &&
                     (sw_raw_reg.reboot <= SWITCH_VALID_MAX);
        centered_next = (stick_next[0] == '0) && (stick_next[1] == '0) &&
                        (stick_next[2] == '0) && (stick_next[3] == '0);
    end

    // ---------------- result register ----------------
    logic signed [STICK_W-1:0] stick_out_reg [NUM_STICKS];
    sw_flags_t                 flags_reg;
    logic                      frame_valid_reg;
    logic                      centered_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stick_out_reg[0] <= stick_next[0];
            stick_out_reg[1] <= stick_next[1];
            stick_out_reg[2] <= stick_next[2];
            stick_out_reg[3] <= stick_next[3];
            flags_reg        <= flags_next;
            frame_valid_reg  <= valid_next;
            centered_reg     <= centered_next;
        end
    end

    assign stick_out_0     = stick_out_reg[0];
    assign stick_out_1     = stick_out_reg[1];
    assign stick_out_2     = stick_out_reg[2];
    assign stick_out_3     = stick_out_reg[3];
    assign hover_active    = flags_reg.hover_active;
    assign hover_entered   = flags_reg.hover_entered;
    assign command_active  = flags_reg.command_active;
    assign command_entered = flags_reg.command_entered;
    assign reboot_pulse    = flags_reg.reboot_pulse;
    assign frame_valid     = frame_valid_reg;
    assign sticks_centered = centered_reg;

    // ---------------- assertions ----------------
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("in_ready low with room in the pipe");

    a_advance_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("result register not loaded after advance");

    a_hover_edge_implies_hover: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hover_entered) |-> hover_active)
        else $error("hover entry without hover");

    a_reboot_excludes_modes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reboot_pulse) |-> (!hover_active && !command_active))
        else $error("reboot pulse while a mode is active");

    a_centered_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sticks_centered == ((stick_out_0 == '0) && (stick_out_1 == '0) &&
                                           (stick_out_2 == '0) && (stick_out_3 == '0))))
        else $error("centered flag disagrees with stick outputs");

endmodule

// File: design/rcsde_stick_lane.sv
// ----------------------------------------------------------------------------
// rcsde_stick_lane: one stick normalizer
// Offset from center, dead zone removal, gain multiply, Q1.14 saturation.
// ----------------------------------------------------------------------------
module rcsde_stick_lane (
    input  logic [rcsde_pkg::RAW_W-1:0]          raw,
    input  logic [rcsde_pkg::DZ_W-1:0]           dz_width,
    input  logic [rcsde_pkg::GAIN_W-1:0]         gain,
    output logic signed [rcsde_pkg::STICK_W-1:0] stick
);
    import rcsde_pkg::*;

    localparam int SUM_W  = RAW_W + 1;
    localparam int PROD_W = RAW_W + GAIN_W;
    localparam int MAG_W  = PROD_W - 16;

    logic [SUM_W-1:0]   raw_ext;
    logic [SUM_W-1:0]   dz_ext;
    logic [SUM_W-1:0]   ctr_ext;
    logic [SUM_W-1:0]   thr_hi;
    logic               is_pos;
    logic               is_neg;
    logic [RAW_W-1:0]   excess;
    logic [PROD_W-1:0]  prod;
    logic [MAG_W-1:0]   mag_full;
    logic [STICK_W-2:0] mag_sat;

    always_comb
    begin
        raw_ext = {1'b0, raw};
        dz_ext  = SUM_W'(dz_width);
        ctr_ext = {1'b0, STICK_CENTER};
        thr_hi  = ctr_ext + dz_ext;
        is_pos  = raw_ext > thr_hi;
        is_neg  = (raw_ext + dz_ext) < ctr_ext;

        if (is_pos)
        begin
            excess = RAW_W'(raw_ext - thr_hi);
        end
        else if (is_neg)
        begin
            excess = RAW_W'(ctr_ext - dz_ext - raw_ext);
        end
        else
        begin
            excess = '0;
        end

        prod     = PROD_W'(excess) * PROD_W'(gain);
        mag_full = prod[PROD_W-1:16];
        mag_sat  = (mag_full > MAG_W'(Q14_ONE)) ? Q14_ONE : mag_full[STICK_W-2:0];

        if (is_neg)
        begin
            stick = -$signed({1'b0, mag_sat});
        end
        else
        begin
            stick = $signed({1'b0, mag_sat});
        end
    end

endmodule

// File: design/rcsde_switch_logic.sv
// ----------------------------------------------------------------------------
// rcsde_switch_logic: switch thresholds, edges and mode flags
// Holds previous switch values and command flags; state moves on advance.
// ----------------------------------------------------------------------------
module rcsde_switch_logic (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  rcsde_pkg::sw_raw_t          sw,
    input  rcsde_pkg::sw_raw_t          thresh,
    output rcsde_pkg::sw_flags_t        flags
);
    import rcsde_pkg::*;

    sw_raw_t prev_reg;
    logic    seen_reg;
    logic    cmd_mode_reg;
    logic    cmd_entry_reg;

    sw_raw_t prev_eff;
    logic    hover;
    logic    cmd_mode_next;
    logic    cmd_entry_next;

    always_comb
    begin
        // first frame seeds the history, so no edge on it
        prev_eff = seen_reg ? prev_reg : sw;
        hover    = sw.mode > thresh.mode;

        cmd_mode_next  = cmd_mode_reg;
        cmd_entry_next = cmd_entry_reg;
        if (hover)
        begin
            if ((prev_eff.gear < thresh.gear) && (sw.gear > thresh.gear))
            begin
                cmd_entry_next = 1'b1;
            end
            else if (sw.gear < thresh.gear)
            begin
                cmd_entry_next = 1'b0;
            end
            cmd_mode_next = sw.gear > thresh.gear;
        end

        flags.hover_active    = hover;
        flags.hover_entered   = (prev_eff.mode < thresh.mode) && hover;
        flags.command_active  = cmd_mode_next;
        flags.command_entered = cmd_entry_next;
        flags.reboot_pulse    = !hover && !cmd_mode_next &&
                                (prev_eff.reboot < thresh.reboot) &&
                                (sw.reboot > thresh.reboot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            seen_reg      <= 1'b0;
            cmd_mode_reg  <= 1'b1;
            cmd_entry_reg <= 1'b0;
        end
        else if (advance)
        begin
            prev_reg      <= sw;
            seen_reg      <= 1'b1;
            cmd_mode_reg  <= cmd_mode_next;
            cmd_entry_reg <= cmd_entry_next;
        end
    end

endmodule
